FILE: hw/rtl/cst_pkg.sv
package cst_pkg;

    localparam int SEM_SLOTS  = 16;
    localparam int COUNT_BITS = 15;
    localparam int IDX_W      = $clog2(SEM_SLOTS);

    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_DOWN   = 2'd2,
        MODE_UP     = 2'd3
    } cst_mode_e;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BAD_ID = 3'd1,
        ST_UNUSED = 3'd2,
        ST_BLOCK  = 3'd3,
        ST_FULL   = 3'd4,
        ST_NEG    = 3'd5,
        ST_SAT    = 3'd6
    } cst_status_e;

    typedef struct packed {
        cst_mode_e          mode;
        logic signed [7:0]  sem_id;
        logic signed [15:0] init_value;
    } cst_in_t;

    typedef struct packed {
        cst_status_e status;
        logic [3:0]  slot_id;
        logic [14:0] count_after;
    } cst_out_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } cst_free_t;

    typedef logic [SEM_SLOTS-1:0]  cst_mask_t;
    typedef logic [COUNT_BITS-1:0] cst_count_t;

endpackage

FILE: hw/rtl/cst_free_enc.sv
module cst_free_enc (
    input  cst_pkg::cst_mask_t free_mask,
    output cst_pkg::cst_free_t pick
);
    import cst_pkg::*;

    always_comb begin
        pick.found = 1'b0;
        pick.idx   = '0;
        for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
            if (free_mask[i]) begin
                pick.found = 1'b1;
                pick.idx   = IDX_W'(i);
            end
        end
    end

endmodule

FILE: hw/rtl/counting_semaphore_table.sv
// counting semaphore bank, one request beat in and one result beat out
//
// s_ channel: request beats (mode, sem_id, init_value) with valid/ready
// m_ channel: result beats (status, slot_id, count_after) with valid/ready
// modes: create claims the lowest free slot, free releases a slot,
// try-down takes one unit or reports would-block, up adds one unit
// or reports saturated
//
// pipeline: a request is captured in an input register, then resolved
// against the in-use flags and counts and written to the result
// register, from which its result beat is offered on the m_ channel.
// throughput is one request per cycle while results are taken; the
// lowest-free search is a single priority encoder over the in-use flags
//
// reset: aresetn low at a clock edge marks every slot free and empties
// both registers. counts are written by create before any read
//
// stall: while m_ready is low the result beat holds; one more request
// is taken into the input register, then s_ready drops until the
// result is taken
module counting_semaphore_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cst_pkg::cst_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cst_pkg::cst_out_t m_data
);
    import cst_pkg::*;

    logic       in_valid_reg;
    cst_in_t    in_data_reg;
    logic       out_valid_reg;
    cst_out_t   out_data_reg;
    cst_mask_t  in_use_reg;
    cst_mask_t  in_use_next;
    cst_count_t sem_count_reg [SEM_SLOTS];

    logic             advance;
    cst_free_t        pick;
    cst_out_t         res_next;
    logic             cnt_we;
    logic [IDX_W-1:0] cnt_waddr;
    cst_count_t       cnt_wdata;

    logic             id_bad;
    logic [IDX_W-1:0] id_idx;
    cst_count_t       cur_cnt;
    logic [31:0]      iv_wide;
    logic [31:0]      cnt_wide;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    cst_free_enc u_free_enc (
        .free_mask(~in_use_reg),
        .pick     (pick)
    );

    assign id_bad  = in_data_reg.sem_id[7]
                  || ({24'd0, in_data_reg.sem_id} >= 32'(SEM_SLOTS));
    assign id_idx  = in_data_reg.sem_id[IDX_W-1:0];
    assign cur_cnt = sem_count_reg[id_idx];
    assign iv_wide = {16'd0, in_data_reg.init_value};

    always_comb begin
        res_next    = '{status: ST_OK, slot_id: 4'd0, count_after: 15'd0};
        in_use_next = in_use_reg;
        cnt_we      = 1'b0;
        cnt_waddr   = id_idx;
        cnt_wdata   = cur_cnt;
        cnt_wide    = 32'd0;
        case (in_data_reg.mode)
            MODE_CREATE: begin
                if (in_data_reg.init_value[15]) begin
                    res_next.status = ST_NEG;
                end else if (iv_wide > COUNT_MAX) begin
                    res_next.status = ST_SAT;
                end else if (!pick.found) begin
                    res_next.status = ST_FULL;
                end else begin
                    in_use_next[pick.idx] = 1'b1;
                    cnt_we               = 1'b1;
                    cnt_waddr            = pick.idx;
                    cnt_wdata            = COUNT_BITS'(iv_wide);
                    cnt_wide             = iv_wide;
                    res_next.slot_id     = 4'(32'(pick.idx));
                    res_next.count_after = cnt_wide[14:0];
                end
            end
            MODE_FREE: begin
                if (id_bad) begin
                    res_next.status = ST_BAD_ID;
                end else begin
                    in_use_next[id_idx] = 1'b1 ^ 1'b1;
                    res_next.slot_id    = 4'(32'(id_idx));
                end
            end
            MODE_DOWN: begin
                if (id_bad) begin
                    res_next.status = ST_BAD_ID;
                end else if (!in_use_reg[id_idx]) begin
                    res_next.status  = ST_UNUSED;
                    res_next.slot_id = 4'(32'(id_idx));
                end else if (cur_cnt == '0) begin
                    res_next.status  = ST_BLOCK;
                    res_next.slot_id = 4'(32'(id_idx));
                end else begin
                    cnt_we               = 1'b1;
                    cnt_wdata            = cur_cnt - COUNT_BITS'(1);
                    cnt_wide             = 32'(cnt_wdata);
                    res_next.slot_id     = 4'(32'(id_idx));
                    res_next.count_after = cnt_wide[14:0];
                end
            end
            MODE_UP: begin
                if (id_bad) begin
                    res_next.status = ST_BAD_ID;
                end else if (!in_use_reg[id_idx]) begin
                    res_next.status  = ST_UNUSED;
                    res_next.slot_id = 4'(32'(id_idx));
                end else if (32'(cur_cnt) >= COUNT_MAX) begin
                    res_next.status  = ST_SAT;
                    res_next.slot_id = 4'(32'(id_idx));
                end else begin
                    cnt_we               = 1'b1;
                    cnt_wdata            = cur_cnt + COUNT_BITS'(1);
                    cnt_wide             = 32'(cnt_wdata);
                    res_next.slot_id     = 4'(32'(id_idx));
                    res_next.count_after = cnt_wide[14:0];
                end
            end
            default: begin
                res_next.status = ST_BAD_ID;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_use_reg    <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                in_use_reg    <= in_use_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= res_next;
        end
        if (aresetn && advance && cnt_we) begin
            sem_count_reg[cnt_waddr] <= cnt_wdata;
        end
    end

    // every error result carries a zero count
    a_err_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_OK)) |-> (m_data.count_after == 15'd0))
        else $error("error result with nonzero count");

    // a bad id never names a slot
    a_bad_id_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_BAD_ID)) |-> (m_data.slot_id == 4'd0))
        else $error("bad id result with nonzero slot");

    // the input register holds while the result register is blocked
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("request taken while pipeline is blocked");

    // flags change only when a request resolves
    a_flags_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance && $past(aresetn)) |=> $stable(in_use_reg))
        else $error("in-use flags changed without a request");

    // reset frees every slot
    a_reset_free: assert property (@(posedge aclk)
        !aresetn |=> (in_use_reg == '0))
        else $error("in-use flags not cleared by reset");

endmodule

FILE: bench/cst_checker.sv
module cst_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  cst_pkg::cst_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  cst_pkg::cst_out_t m_data,
    output int unsigned       mismatches,
    output int unsigned       pending,
    output int unsigned       checked,
    output logic [7:0]        status_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import cst_pkg::*;

    logic       slot_busy  [SEM_SLOTS];
    cst_count_t slot_count [SEM_SLOTS];
    cst_out_t   result_q [$];
    int unsigned n_bad = 0;
    int unsigned n_checked = 0;
    logic [7:0]  seen = '0;

    // applies one request to the semaphore bank copy and returns its result beat
    function automatic cst_out_t predict_result(input cst_in_t req);
        cst_out_t res;
        int       id;
        bit       claimed;
        res.status      = ST_OK;
        res.slot_id     = '0;
        res.count_after = '0;
        id      = int'(req.sem_id);
        claimed = 1'b0;
        if (req.mode == MODE_CREATE) begin
            if (req.init_value < 0) begin
                res.status = ST_NEG;
            end else if (int'(req.init_value) > int'(COUNT_MAX)) begin
                res.status = ST_SAT;
            end else begin
                for (int i = 0; i < SEM_SLOTS; i++) begin
                    if (!claimed && !slot_busy[i]) begin
                        claimed         = 1'b1;
                        slot_busy[i]    = 1'b1;
                        slot_count[i]   = cst_count_t'(req.init_value);
                        res.slot_id     = 4'(i);
                        res.count_after = 15'(slot_count[i]);
                    end
                end
                if (!claimed) begin
                    res.status = ST_FULL;
                end
            end
        end else if (id < 0 || id >= SEM_SLOTS) begin
            res.status = ST_BAD_ID;
        end else begin
            res.slot_id = 4'(id);
            if (req.mode == MODE_FREE) begin
                slot_busy[id] = 1'b0;
            end else if (!slot_busy[id]) begin
                res.status = ST_UNUSED;
            end else if (req.mode == MODE_DOWN) begin
                if (slot_count[id] == '0) begin
                    res.status = ST_BLOCK;
                end else begin
                    slot_count[id]  = slot_count[id] - 1'b1;
                    res.count_after = 15'(slot_count[id]);
                end
            end else begin
                if (slot_count[id] == cst_count_t'(COUNT_MAX)) begin
                    res.status = ST_SAT;
                end else begin
                    slot_count[id]  = slot_count[id] + 1'b1;
                    res.count_after = 15'(slot_count[id]);
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        cst_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < SEM_SLOTS; i++) begin
                slot_busy[i]  = 1'b0;
                slot_count[i] = '0;
            end
            result_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                result_q.push_back(predict_result(s_data));
            end
            if (m_valid && m_ready) begin
                n_checked++;
                seen[m_data.status] = 1'b1;
                if (result_q.size() == 0) begin
                    if (n_bad < 10) begin
                        $display("[%0t] result beat with nothing outstanding: %s",
                                 $realtime, "");
                        $display("    status %0d slot %0d count %0d",
                                 m_data.status, m_data.slot_id, m_data.count_after);
                    end
                    n_bad++;
                end else begin
                    want = result_q.pop_front();
                    if (want.status !== m_data.status || want.slot_id !== m_data.slot_id ||
                        want.count_after !== m_data.count_after) begin
                        if (n_bad < 10) begin
                            $display("[%0t] result mismatch", $realtime);
                            $display("    expected status %0d slot %0d count %0d",
                                     want.status, want.slot_id, want.count_after);
                            $display("    got      status %0d slot %0d count %0d",
                                     m_data.status, m_data.slot_id, m_data.count_after);
                        end
                        n_bad++;
                    end
                end
            end
        end
        mismatches  <= n_bad;
        pending     <= result_q.size();
        checked     <= n_checked;
        status_seen <= seen;
    end

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cst_pkg::*;

    localparam int unsigned RANDOM_REQS    = 1950;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cst_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cst_out_t m_data;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned checked;
    logic [7:0]  status_seen;

    int unsigned n_sent = 0;
    int unsigned n_directed = 0;
    int unsigned idle_cycles = 0;
    bit          calm = 1'b0;

    always #4 aclk = ~aclk;

    counting_semaphore_table u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cst_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .status_seen (status_seen)
    );

    // mostly short gaps, a few long ones, none during calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic cst_in_t make_req(input cst_mode_e mode, input int id, input int iv);
        cst_in_t r;
        r.mode       = mode;
        r.sem_id     = 8'(id);
        r.init_value = 16'(iv);
        return r;
    endfunction

    task automatic send_req(input cst_in_t req);
        int unsigned gap;
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic cst_in_t random_req();
        int unsigned r;
        int          id;
        int          iv;
        cst_mode_e   mode;
        r = $urandom_range(0, 99);
        if (r < 28) begin
            mode = MODE_CREATE;
        end else if (r < 48) begin
            mode = MODE_FREE;
        end else if (r < 73) begin
            mode = MODE_DOWN;
        end else begin
            mode = MODE_UP;
        end
        if ($urandom_range(0, 99) < 85) begin
            id = $urandom_range(0, SEM_SLOTS - 1);
        end else begin
            id = $urandom_range(0, 255);
        end
        iv = $urandom_range(0, 65535);
        if (mode == MODE_CREATE) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                iv = $urandom_range(0, 3);
            end else if (r < 65) begin
                iv = $urandom_range(32765, 32767);
            end else if (r < 90) begin
                iv = $urandom_range(0, 32767);
            end
        end
        return make_req(mode, id, iv);
    endfunction

    // receiver side: bursts of ready with random stalls between them
    initial begin : sink
        int unsigned stall;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = pick_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("counting_semaphore_table regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // fill the bank, then push it past full
        for (int i = 0; i < SEM_SLOTS; i++) begin
            send_req(make_req(MODE_CREATE, $urandom_range(0, 255),
                              (i == 0) ? 0 : (i == 1) ? 32767 : $urandom_range(1, 100)));
        end
        send_req(make_req(MODE_CREATE, 0, 5));
        send_req(make_req(MODE_DOWN, 0, 0));
        send_req(make_req(MODE_UP, 1, 0));
        send_req(make_req(MODE_DOWN, 1, 0));
        send_req(make_req(MODE_CREATE, 3, -32768));
        send_req(make_req(MODE_DOWN, -128, 0));
        send_req(make_req(MODE_FREE, SEM_SLOTS, 0));
        send_req(make_req(MODE_FREE, 9, 0));
        send_req(make_req(MODE_FREE, 9, -1));
        send_req(make_req(MODE_DOWN, 9, 0));
        send_req(make_req(MODE_UP, 9, 0));
        n_directed = n_sent;

        for (int k = 0; k < RANDOM_REQS; k++) begin
            if (k % 150 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            send_req(random_req());
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d request beats (%0d directed), checked %0d result beats",
                 n_sent, n_directed, checked);
        $display("status codes returned, one bit per code from ok upward: %b",
                 status_seen[6:0]);
        if (mismatches == 0 && pending == 0) begin
            $display("counting_semaphore_table regression: pass");
        end else begin
            $display("counting_semaphore_table regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/cst_pkg.sv
hw/rtl/cst_free_enc.sv
hw/rtl/counting_semaphore_table.sv
bench/cst_checker.sv
bench/tb.sv
